@@ sv/mbsp_pkg.sv @@
package mbsp_pkg;

    // Message groups
    localparam logic [1:0] GRP_CHANNEL = 2'd0;
    localparam logic [1:0] GRP_SYSTEM  = 2'd1;
    localparam logic [1:0] GRP_RT      = 2'd2;
    localparam logic [1:0] GRP_SYSEX   = 2'd3;

    // Types within the system common group
    localparam logic [2:0] SYS_TUNE_REQ = 3'd3;

    // Types within the real-time group
    localparam logic [2:0] RT_CLOCK    = 3'd0;
    localparam logic [2:0] RT_START    = 3'd1;
    localparam logic [2:0] RT_CONTINUE = 3'd2;
    localparam logic [2:0] RT_STOP     = 3'd3;
    localparam logic [2:0] RT_SENSE    = 3'd4;
    localparam logic [2:0] RT_RESET    = 3'd5;

    // Types within the sysex group
    localparam logic [2:0] SX_BEGIN = 3'd0;
    localparam logic [2:0] SX_DATA  = 3'd1;
    localparam logic [2:0] SX_END   = 3'd2;

    // Low nibble of system status bytes (high nibble 0xF)
    localparam logic [3:0] ST_SX_BEGIN  = 4'h0;
    localparam logic [3:0] ST_QFRAME    = 4'h1;
    localparam logic [3:0] ST_SONG_POS  = 4'h2;
    localparam logic [3:0] ST_SONG_SEL  = 4'h3;
    localparam logic [3:0] ST_UNDEF_4   = 4'h4;
    localparam logic [3:0] ST_UNDEF_5   = 4'h5;
    localparam logic [3:0] ST_TUNE_REQ  = 4'h6;
    localparam logic [3:0] ST_SX_END    = 4'h7;
    localparam logic [3:0] ST_CLOCK     = 4'h8;
    localparam logic [3:0] ST_UNDEF_9   = 4'h9;
    localparam logic [3:0] ST_START     = 4'hA;
    localparam logic [3:0] ST_CONTINUE  = 4'hB;
    localparam logic [3:0] ST_STOP      = 4'hC;
    localparam logic [3:0] ST_UNDEF_D   = 4'hD;
    localparam logic [3:0] ST_SENSE     = 4'hE;
    localparam logic [3:0] ST_RESET     = 4'hF;

    localparam logic [3:0] HI_SYSTEM = 4'hF;

    // Pending message kinds: channel kinds are type plus one,
    // system common kinds start at KIND_SYS_BASE.
    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_SYS_BASE = 4'd8;

    // Channel types that carry a single data byte
    localparam logic [2:0] CH_PROGRAM  = 3'd4;
    localparam logic [2:0] CH_PRESSURE = 3'd5;

    typedef struct packed {
        logic       in_sysex;
        logic [3:0] pending_kind;
        logic [3:0] pending_channel;
        logic [1:0] expected_count;
        logic [1:0] received_count;
        logic [6:0] data0;
        logic [6:0] data1;
    } t_state;

    typedef struct packed {
        logic [1:0] msg_group;
        logic [2:0] msg_type;
        logic [3:0] midi_channel;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [1:0] data_count;
    } t_result;

endpackage

@@ sv/mbsp_if.sv @@
interface mbsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbsp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] msg_group;
    logic [2:0] msg_type;
    logic [3:0] midi_channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [1:0] data_count;

    modport source (
        output valid, output msg_group, output msg_type, output midi_channel,
        output first_data, output second_data, output data_count, input ready
    );
    modport sink (
        input valid, input msg_group, input msg_type, input midi_channel,
        input first_data, input second_data, input data_count, output ready
    );
endinterface

@@ sv/mbsp_core.sv @@
module mbsp_core
    import mbsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_state r_state;
    t_state n_state;

    logic [3:0] hi;
    logic [3:0] lo;
    logic [2:0] ch_type;
    logic [1:0] rcvd_inc;
    t_state     cleared;

    assign hi       = i_byte[7:4];
    assign lo       = i_byte[3:0];
    assign ch_type  = hi[2:0];
    assign rcvd_inc = r_state.received_count + 2'd1;

    always_comb begin
        cleared                 = '0;
        cleared.in_sysex        = r_state.in_sysex;
    end

    always_comb begin
        n_state     = r_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!i_byte[7]) begin
            if (r_state.in_sysex) begin
                o_res_valid      = 1'b1;
                o_res.msg_group  = GRP_SYSEX;
                o_res.msg_type   = SX_DATA;
                o_res.first_data = i_byte[6:0];
            end else if (r_state.pending_kind != KIND_NONE &&
                         r_state.received_count < r_state.expected_count) begin
                if (r_state.received_count[0]) begin
                    n_state.data1 = i_byte[6:0];
                end else begin
                    n_state.data0 = i_byte[6:0];
                end
                n_state.received_count = rcvd_inc;
                if (rcvd_inc == r_state.expected_count) begin
                    o_res_valid       = 1'b1;
                    o_res.first_data  = n_state.data0;
                    o_res.second_data = n_state.data1;
                    o_res.data_count  = r_state.expected_count;
                    if (r_state.pending_kind < KIND_SYS_BASE) begin
                        o_res.msg_group    = GRP_CHANNEL;
                        o_res.msg_type     = 3'(r_state.pending_kind - 4'd1);
                        o_res.midi_channel = r_state.pending_channel;
                    end else begin
                        o_res.msg_group = GRP_SYSTEM;
                        o_res.msg_type  = 3'(r_state.pending_kind - KIND_SYS_BASE);
                    end
                end
            end
        end else if (hi != HI_SYSTEM) begin
            n_state                 = cleared;
            n_state.pending_kind    = {1'b0, ch_type} + 4'd1;
            n_state.pending_channel = lo;
            n_state.expected_count  =
                (ch_type == CH_PROGRAM || ch_type == CH_PRESSURE) ? 2'd1 : 2'd2;
        end else begin
            unique case (lo)
                ST_UNDEF_4, ST_UNDEF_5, ST_UNDEF_9, ST_UNDEF_D: begin
                    n_state = r_state;
                end
                ST_SX_BEGIN: begin
                    n_state          = cleared;
                    n_state.in_sysex = 1'b1;
                    o_res_valid      = 1'b1;
                    o_res.msg_group  = GRP_SYSEX;
                    o_res.msg_type   = SX_BEGIN;
                end
                ST_QFRAME, ST_SONG_POS, ST_SONG_SEL: begin
                    n_state                = cleared;
                    n_state.pending_kind   = KIND_SYS_BASE + {2'b00, lo[1:0]} - 4'd1;
                    n_state.expected_count = (lo == ST_SONG_POS) ? 2'd2 : 2'd1;
                end
                ST_TUNE_REQ: begin
                    n_state         = cleared;
                    o_res_valid     = 1'b1;
                    o_res.msg_group = GRP_SYSTEM;
                    o_res.msg_type  = SYS_TUNE_REQ;
                end
                ST_SX_END: begin
                    n_state          = cleared;
                    n_state.in_sysex = 1'b0;
                    o_res_valid      = 1'b1;
                    o_res.msg_group  = GRP_SYSEX;
                    o_res.msg_type   = SX_END;
                end
                ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_SENSE, ST_RESET: begin
                    n_state         = cleared;
                    o_res_valid     = 1'b1;
                    o_res.msg_group = GRP_RT;
                    case (lo)
                        ST_CLOCK:    o_res.msg_type = RT_CLOCK;
                        ST_START:    o_res.msg_type = RT_START;
                        ST_CONTINUE: o_res.msg_type = RT_CONTINUE;
                        ST_STOP:     o_res.msg_type = RT_STOP;
                        ST_SENSE:    o_res.msg_type = RT_SENSE;
                        default:     o_res.msg_type = RT_RESET;
                    endcase
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/mbsp_out_reg.sv @@
module mbsp_out_reg
    import mbsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_can_load,
    mbsp_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    // The register can take a new result when empty or when its content
    // leaves in this cycle.
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= i_res_valid;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.msg_group    = r_res.msg_group;
    assign o_out.msg_type     = r_res.msg_type;
    assign o_out.midi_channel = r_res.midi_channel;
    assign o_out.first_data   = r_res.first_data;
    assign o_out.second_data  = r_res.second_data;
    assign o_out.data_count   = r_res.data_count;

endmodule

@@ sv/midi_byte_stream_parser.sv @@
// MIDI byte stream parser: takes one received byte per transfer and gives at
// most one decoded message (channel, system common, real-time or sysex) per
// byte. One byte is accepted every cycle while input is not held back. The
// byte's transfer loads the input register; the core then steps on that byte
// and loads its result into the result register, from which the sink takes
// it. Input is held back only while the result register holds a result that
// the sink has not taken. Running status is not supported, undefined status
// bytes are ignored, and extra data bytes after a complete message are
// dropped.
module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbsp_in_if.sink    i_in,
    mbsp_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_load;
    logic       step;
    logic       res_valid;
    t_result    res;

    assign step       = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    mbsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mbsp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_load  (can_load),
        .o_out       (o_out)
    );

endmodule
